/* rtl/rhc_pkg.sv */
// Shared types, widths and constants for the RGB to HSV converter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rhc_pkg;

  localparam int BYTE_W        = 8;
  localparam int HUE_W         = 15;
  localparam int HUE_FRAC_BITS = 6;

  // Hue geometry in degrees.
  localparam int HUE_SLOPE_DEG     = 60;
  localparam int SECTOR_GREEN_DEG  = 120;
  localparam int SECTOR_BLUE_DEG   = 240;
  localparam int FULL_TURN_DEG     = 360;
  localparam int HUE_TURN          = FULL_TURN_DEG << HUE_FRAC_BITS;

  // Twice the saturation full scale; the divisor is doubled for rounding.
  localparam int SAT_SCALE2 = 510;

  // The hue numerator before scaling stays below 360 * 255.
  localparam int NUM_W  = $clog2(FULL_TURN_DEG * 255 + 1);
  // Quotient bits: the rounded hue may reach one full turn before wrapping.
  localparam int QUO_W  = $clog2(HUE_TURN + 1);
  // Divisors are a doubled byte.
  localparam int DIV_W  = BYTE_W + 1;
  localparam int DEND_W = DIV_W + QUO_W;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha_in;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [BYTE_W-1:0] saturation;
    logic [BYTE_W-1:0] brightness;
    logic [BYTE_W-1:0] alpha_out;
  } hsv_t;

  // One long division in flight: the partial remainder, and a word that
  // holds the dividend bits still to come at its top and the quotient bits
  // found so far at its bottom.
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] lo;
    logic [DIV_W-1:0] div;
  } lane_t;

  typedef struct packed {
    lane_t             hue_lane;
    lane_t             sat_lane;
    logic [BYTE_W-1:0] brightness;
    logic [BYTE_W-1:0] alpha;
    logic              grey;
    logic              black;
  } stage_t;

endpackage

`default_nettype wire

/* rtl/rhc_prep.sv */
// Front stage of the converter: max, min, hue sector and both dividends.
// Depends on rhc_pkg.
`default_nettype none

module rhc_prep import rhc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  input  pixel_t up_data,
  output logic   up_ready,
  output logic   dn_valid,
  output stage_t dn_data,
  input  logic   dn_ready
);

  logic [BYTE_W-1:0]        r, g, b, mx, mn, span;
  logic signed [BYTE_W:0]   diff;
  logic [NUM_W-1:0]         offset_term, turn_term, num_pos;
  logic signed [NUM_W:0]    slope_term, num_raw;
  logic [DEND_W-1:0]        hue_dend, sat_dend;
  stage_t                   stage_next;

  always_comb begin
    r = up_data.red;
    g = up_data.green;
    b = up_data.blue;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    span = mx - mn;

    // Red wins ties over green, green over blue.
    if (mx == r) begin
      diff        = $signed({1'b0, g}) - $signed({1'b0, b});
      offset_term = '0;
    end else if (mx == g) begin
      diff        = $signed({1'b0, b}) - $signed({1'b0, r});
      offset_term = NUM_W'(span) * NUM_W'(SECTOR_GREEN_DEG);
    end else begin
      diff        = $signed({1'b0, r}) - $signed({1'b0, g});
      offset_term = NUM_W'(span) * NUM_W'(SECTOR_BLUE_DEG);
    end

    slope_term = $signed((NUM_W+1)'(diff)) * $signed((NUM_W+1)'(HUE_SLOPE_DEG));
    num_raw    = $signed({1'b0, offset_term}) + slope_term;
    turn_term  = NUM_W'(span) * NUM_W'(FULL_TURN_DEG);
    // A negative hue is wrapped by one full turn before rounding.
    num_pos    = num_raw[NUM_W] ? num_raw[NUM_W-1:0] + turn_term : num_raw[NUM_W-1:0];

    // Rounded quotients: (2n + d) / 2d.
    hue_dend = (DEND_W'(num_pos) << (HUE_FRAC_BITS + 1)) + DEND_W'(span);
    sat_dend = DEND_W'(span) * DEND_W'(SAT_SCALE2) + DEND_W'(mx);

    stage_next.hue_lane.rem = hue_dend[DEND_W-1:QUO_W];
    stage_next.hue_lane.lo  = hue_dend[QUO_W-1:0];
    stage_next.hue_lane.div = {span, 1'b0};
    stage_next.sat_lane.rem = sat_dend[DEND_W-1:QUO_W];
    stage_next.sat_lane.lo  = sat_dend[QUO_W-1:0];
    stage_next.sat_lane.div = {mx, 1'b0};
    stage_next.brightness   = mx;
    stage_next.alpha        = up_data.alpha_in;
    stage_next.grey         = (span == '0);
    stage_next.black        = (mx == '0);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rhc_div_cell.sv */
// One cell of the division chain: a restoring step for the hue and the
// saturation quotient, then a register. Depends on rhc_pkg.
`default_nettype none

module rhc_div_cell import rhc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  input  stage_t up_data,
  output logic   up_ready,
  output logic   dn_valid,
  output stage_t dn_data,
  input  logic   dn_ready
);

  function automatic lane_t lane_step(lane_t lane);
    logic [DIV_W:0] trial;
    lane_t          nxt;
    trial = {lane.rem, lane.lo[QUO_W-1]};
    nxt   = lane;
    if (trial >= {1'b0, lane.div}) begin
      nxt.rem = DIV_W'(trial - {1'b0, lane.div});
      nxt.lo  = {lane.lo[QUO_W-2:0], 1'b1};
    end else begin
      nxt.rem = trial[DIV_W-1:0];
      nxt.lo  = {lane.lo[QUO_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  stage_t stage_next;

  always_comb begin
    stage_next          = up_data;
    stage_next.hue_lane = lane_step(up_data.hue_lane);
    stage_next.sat_lane = lane_step(up_data.sat_lane);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rgb_to_hsv_convert.sv */
// Top level of the RGB to HSV converter: front stage, division chain and
// output register. Depends on rhc_pkg, rhc_prep and rhc_div_cell.
//
// Usage. Pixels come in on the pixel channel (pixel_valid, pixel_stall,
// pixel) and HSV results leave on the hsv channel (hsv_valid, hsv_stall,
// hsv). A transfer happens at a rising edge where valid is high and stall
// is low. Every pixel gives exactly one result, in order.
// Hue is in 1/64 degree, saturation and brightness are bytes, alpha passes
// through unchanged.
// A pixel passes from the transfer to hsv_valid through the front stage,
// the chain of division cells (one quotient bit per cell, hue and
// saturation side by side) and the output register, each registered.
// Throughput is one pixel per cycle while hsv_stall is low; the chain length
// sets the latency, and a cell passes an item on whenever its successor takes it.
// Each stage has its own valid bit and loads when it is empty or its
// successor takes its item, so while the receiver stalls the chain keeps
// filling its gaps; pixel_stall rises only once every stage holds a pixel.
// A synchronous reset empties all stages; no configuration is needed.
`default_nettype none

module rgb_to_hsv_convert import rhc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  input  pixel_t pixel,
  output logic   hsv_valid,
  input  logic   hsv_stall,
  output hsv_t   hsv
);

  // Position 0 is the front stage output, position QUO_W the last cell.
  logic [QUO_W:0] chain_valid;
  logic [QUO_W:0] chain_take;
  stage_t         chain_data [QUO_W+1];
  logic           prep_ready;
  logic           out_load;
  logic [QUO_W-1:0] hue_q, hue_wrap;
  hsv_t           hsv_next;

  assign pixel_stall = !prep_ready;

  rhc_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pixel_valid),
    .up_data  (pixel),
    .up_ready (prep_ready),
    .dn_valid (chain_valid[0]),
    .dn_data  (chain_data[0]),
    .dn_ready (chain_take[0])
  );

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    rhc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[k]),
      .up_data  (chain_data[k]),
      .up_ready (chain_take[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_data  (chain_data[k+1]),
      .dn_ready (chain_take[k+1])
    );
  end

  // The rounded hue can land on exactly one full turn, which wraps to zero.
  // Grey pixels have no hue and black pixels no saturation; their divisors
  // are zero, so the chain's quotients are replaced here.
  always_comb begin
    hue_q    = chain_data[QUO_W].hue_lane.lo;
    hue_wrap = (hue_q >= QUO_W'(HUE_TURN)) ? hue_q - QUO_W'(HUE_TURN) : hue_q;
    hsv_next.hue        = chain_data[QUO_W].grey ? '0 : HUE_W'(hue_wrap);
    hsv_next.saturation = chain_data[QUO_W].black ? '0 :
                          chain_data[QUO_W].sat_lane.lo[BYTE_W-1:0];
    hsv_next.brightness = chain_data[QUO_W].brightness;
    hsv_next.alpha_out  = chain_data[QUO_W].alpha;
  end

  assign out_load          = !hsv_valid || !hsv_stall;
  assign chain_take[QUO_W] = out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (out_load) begin
      hsv_valid <= chain_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && chain_valid[QUO_W]) begin
      hsv <= hsv_next;
    end
  end

  // The input is held off only when the whole pipeline is full and blocked.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (hsv_valid && hsv_stall && chain_valid[0] && chain_valid[QUO_W]))
    else $error("input stalled while the pipeline has room");

  // A black pixel has zero saturation.
  a_black_no_sat: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv.brightness == '0) |-> (hsv.saturation == '0))
    else $error("black pixel with nonzero saturation");

  // Zero saturation only comes from a grey pixel, whose hue is zero.
  a_grey_no_hue: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv.saturation == '0) |-> (hsv.hue == '0))
    else $error("grey pixel with nonzero hue");

endmodule

`default_nettype wire
